// File: hdl/dds_pkg.sv
// Shared types and field widths of the descending distance sorter.
package dds_pkg;

    localparam int TAG_BITS  = 16;
    localparam int DIST_BITS = 32;

    typedef struct packed {
        logic [TAG_BITS-1:0]         item_tag;
        logic signed [DIST_BITS-1:0] distance;
        logic                        last_item;
    } dds_item_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]         sorted_tag;
        logic signed [DIST_BITS-1:0] sorted_distance;
        logic                        last_result;
    } dds_result_t;

endpackage

// File: hdl/dds_store.sv
// Entry store of the sorter: one write port, one read port, registered read data.
module dds_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/descending_distance_sorter_unit.sv
// Top level of the descending distance sorter: insertion sequencer, key compare and emit.
//
// Load a list one transaction at a time (start high while busy is low); each item is
// inserted into a store kept in descending key order, equal keys in arrival order.
// Inserting an item walks down from the end of the held list, one entry per cycle
// through the read and write ports of the store and one signed key compare:
// each held entry with a strictly smaller key moves up one place, and the new item
// is written into the place above the first entry that is not smaller, or at the
// head of the list; busy stays high after the accepting cycle until it is placed.
// An item that arrives with MAX_ITEMS items held is dropped. The item marked
// last_item, after its own insertion or its drop, starts the emit:
// one result per held entry on consecutive cycles, farthest first, each shown for
// exactly one cycle with result_valid high, the final one with last_result set.
// Results are registered behind the emit states; the final result appears in the
// cycle after busy falls. The receiver cannot stall results, so sample
// result on every cycle where result_valid is high. The key is the low KEY_BITS
// of distance (zero-extended when KEY_BITS exceeds 32), and sorted_distance returns
// the key sign-extended to 32 bits, or its low 32 bits when wider. No clearing pass follows reset.
module descending_distance_sorter_unit #(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_BITS  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  dds_pkg::dds_item_t  item,
    output logic                result_valid,
    output dds_pkg::dds_result_t result
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int EW = KEY_BITS + dds_pkg::TAG_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_PLACE,
        ST_EMIT
    } state_t;

    state_t                          state_reg;
    logic [CW-1:0]                   count_reg;
    logic [AW-1:0]                   pos_reg;
    logic signed [KEY_BITS-1:0]      key_reg;
    logic [dds_pkg::TAG_BITS-1:0]    tag_reg;
    logic                            last_reg;
    logic                            emit_valid_reg;
    logic                            emit_last_reg;

    logic signed [KEY_BITS-1:0]      key_in;
    logic signed [KEY_BITS-1:0]      rd_key;
    logic [dds_pkg::DIST_BITS-1:0]   dist_out;

    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    logic [EW-1:0]                   wr_data;
    logic                            rd_en;
    logic [AW-1:0]                   rd_addr;
    logic [EW-1:0]                   rd_data;

    logic                            accept;
    logic                            full;
    logic                            held_less;
    logic                            emit_at_end;

    // Form the sort key from the incoming distance.
    generate
        if (KEY_BITS > dds_pkg::DIST_BITS)
        begin : g_key_wide
            assign key_in = {{(KEY_BITS - dds_pkg::DIST_BITS){1'b0}}, item.distance};
            assign dist_out = rd_key[dds_pkg::DIST_BITS-1:0];
        end
        else if (KEY_BITS == dds_pkg::DIST_BITS)
        begin : g_key_same
            assign key_in = item.distance;
            assign dist_out = rd_key;
        end
        else
        begin : g_key_narrow
            assign key_in = item.distance[KEY_BITS-1:0];
            assign dist_out = {{(dds_pkg::DIST_BITS - KEY_BITS){rd_key[KEY_BITS-1]}}, rd_key};
        end
    endgenerate

    assign rd_key = rd_data[EW-1:dds_pkg::TAG_BITS];

    assign accept      = start && !busy;
    assign full        = (count_reg == CW'(MAX_ITEMS));
    // Shift only on strictly smaller held key, which keeps equal keys in arrival order.
    assign held_less   = (rd_key < key_reg);
    assign emit_at_end = (CW'(pos_reg) == (count_reg - CW'(1)));
    assign busy        = (state_reg != ST_IDLE);

    // Store port steering: the sequencer owns one read and one write per cycle.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = {key_reg, tag_reg};
        rd_en   = 1'b0;
        rd_addr = pos_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Fetch the current tail entry for the first compare.
                rd_en   = accept && !full && (count_reg != '0);
                rd_addr = AW'(count_reg - CW'(1));
            end
            ST_CMP:
            begin
                wr_en = 1'b1;
                if (held_less)
                begin
                    // Move the held entry up one place and fetch the next one down.
                    wr_data = rd_data;
                    rd_en   = (pos_reg > AW'(1));
                    rd_addr = pos_reg - AW'(2);
                end
            end
            ST_PLACE:
            begin
                wr_en = 1'b1;
            end
            ST_EMIT:
            begin
                rd_en = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    dds_store #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (EW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer: insertion walk, placement, then emit when the list is closed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pos_reg        <= '0;
            key_reg        <= '0;
            tag_reg        <= '0;
            last_reg       <= 1'b0;
            emit_valid_reg <= 1'b0;
            emit_last_reg  <= 1'b0;
        end
        else
        begin
            emit_valid_reg <= 1'b0;
            emit_last_reg  <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        key_reg  <= key_in;
                        tag_reg  <= item.item_tag;
                        last_reg <= item.last_item;
                        if (!full)
                        begin
                            pos_reg   <= AW'(count_reg);
                            state_reg <= (count_reg == '0) ? ST_PLACE : ST_CMP;
                        end
                        else if (item.last_item)
                        begin
                            // Drop the item but still emit the held list.
                            pos_reg   <= '0;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_CMP:
                begin
                    if (held_less)
                    begin
                        pos_reg <= pos_reg - AW'(1);
                        if (pos_reg == AW'(1))
                        begin
                            state_reg <= ST_PLACE;
                        end
                    end
                    else
                    begin
                        count_reg <= count_reg + CW'(1);
                        pos_reg   <= '0;
                        state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_PLACE:
                begin
                    count_reg <= count_reg + CW'(1);
                    pos_reg   <= '0;
                    state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT:
                begin
                    emit_valid_reg <= 1'b1;
                    emit_last_reg  <= emit_at_end;
                    if (emit_at_end)
                    begin
                        count_reg <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + AW'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid           = emit_valid_reg;
    assign result.sorted_tag      = rd_data[dds_pkg::TAG_BITS-1:0];
    assign result.sorted_distance = dist_out;
    assign result.last_result     = emit_last_reg;

    // The held count never exceeds the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ITEMS))
        else $error("item count exceeds store depth");

    // A result only follows an emit cycle of the sequencer.
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_EMIT))
        else $error("result strobe without emit");

    // The final result closes the list: no strobe in the next cycle.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_result) |=> !result_valid)
        else $error("result follows the final result");

    // An accepted item with room in the store always starts an insertion.
    a_insert_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !full) |=> busy)
        else $error("accepted item not inserted");

endmodule
